>>> rtl/ffc_pkg.sv
// Shared types, codes and constants for the four-function calculator control block
`timescale 1ns / 1ps

package ffc_pkg;

   // fixed field and state widths
   localparam int VAL_W   = 64;
   localparam int ENTRY_W = 48;
   localparam int COUNT_W = 4;
   localparam int DIGIT_W = 4;
   localparam int KIND_W  = 2;
   localparam int OPC_W   = 2;
   localparam int PEND_W  = 3;

   localparam logic [VAL_W-1:0]   SMAX      = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic [VAL_W-1:0]   SMIN      = {1'b1, {(VAL_W-1){1'b0}}};
   localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

   // key event kinds
   typedef enum logic [OPC_W-1:0] {
      OPC_DIGIT,
      OPC_OPERATOR,
      OPC_EQUALS,
      OPC_CLEAR
   } opcode_type;

   // pending operation codes
   typedef enum logic [PEND_W-1:0] {
      PEND_NONE,
      PEND_ADD,
      PEND_SUB,
      PEND_MUL,
      PEND_DIV
   } pend_type;

   // source of a new stored value
   typedef enum logic [1:0] {
      SRC_RIGHT,
      SRC_ADD,
      SRC_SUB,
      SRC_MDU
   } src_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_CONVERT,
      ST_MDU_GO,
      ST_MDU_WAIT,
      ST_WRITE,
      ST_FINISH
   } ctl_state_type;

   // multiply/divide unit states
   typedef enum logic [1:0] {
      MDU_IDLE,
      MDU_RUN,
      MDU_FIX,
      MDU_SIGN
   } mdu_state_type;

   // controller to datapath
   typedef struct packed {
      logic    load_item;
      logic    digit_step;
      logic    clear_all;
      logic    convert;
      logic    mdu_start;
      logic    write_stored;
      src_type src;
      logic    set_pend;
      logic    clr_pend;
      logic    load_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      opcode_type opcode;
      logic       entry_present;
      logic       stored_valid;
      pend_type   pend;
      logic       mdu_done;
   } status_type;

endpackage

>>> rtl/ffc_req_if.sv
// Key event channel: valid/ready handshake with the event fields
`timescale 1ns / 1ps

interface ffc_req_if;
   import ffc_pkg::*;

   logic               valid;
   logic               ready;
   logic [OPC_W-1:0]   opcode;
   logic [DIGIT_W-1:0] digit_value;
   logic [KIND_W-1:0]  operator_kind;

   modport source (output valid, output opcode, output digit_value, output operator_kind,
                   input ready);
   modport sink   (input valid, input opcode, input digit_value, input operator_kind,
                   output ready);
endinterface

>>> rtl/ffc_rsp_if.sv
// Display channel: valid/ready handshake with the shown value and flags
`timescale 1ns / 1ps

interface ffc_rsp_if;
   import ffc_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] display_value;
   logic                    showing_entry;
   logic                    overflow_flag;

   modport source (output valid, output display_value, output showing_entry,
                   output overflow_flag, input ready);
   modport sink   (input valid, input display_value, input showing_entry,
                   input overflow_flag, output ready);
endinterface

>>> rtl/ffc_mdu.sv
// Iterative fixed-point multiply/divide unit, one bit per cycle, rounding and saturation
`timescale 1ns / 1ps

module ffc_mdu #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        is_div,
   input  logic [ffc_pkg::VAL_W-1:0]   a,
   input  logic [ffc_pkg::VAL_W-1:0]   b,
   output logic                        done,
   output logic [ffc_pkg::VAL_W-1:0]   result,
   output logic                        overflow
);
   import ffc_pkg::*;

   localparam int QW    = VAL_W + FRAC_BITS;
   localparam int PW    = 2 * VAL_W;
   localparam int CNT_W = $clog2(QW);
   localparam logic [VAL_W-1:0] HALF = (VAL_W'(1) << FRAC_BITS) >> 1;

   mdu_state_type    state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic             div_ff, div_in;
   logic             neg_ff, neg_in;
   logic             zero_ff, zero_in;
   logic [VAL_W-1:0] opd_ff, opd_in;
   logic [PW-1:0]    acc_ff, acc_in;
   logic [QW-1:0]    num_ff, num_in;
   logic [VAL_W-1:0] rem_ff, rem_in;
   logic [VAL_W-1:0] lo_ff, lo_in;
   logic             big_ff, big_in;
   logic [VAL_W-1:0] result_ff, result_in;
   logic             ovf_ff, ovf_in;

   logic [VAL_W-1:0] mag_a, mag_b, lim, addend;
   logic [VAL_W:0]   sum_hi, rr, rr_diff;
   logic             ge, rnd;
   logic [PW-1:0]    prod_sh;
   logic [QW:0]      quot;

   // operand magnitudes and shared arithmetic
   always_comb begin
      mag_a   = a[VAL_W-1] ? (VAL_W'(0) - a) : a;
      mag_b   = b[VAL_W-1] ? (VAL_W'(0) - b) : b;
      lim     = neg_ff ? SMIN : SMAX;
      addend  = acc_ff[0] ? opd_ff : '0;
      sum_hi  = {1'b0, acc_ff[PW-1:VAL_W]} + {1'b0, addend};
      rr      = {rem_ff, num_ff[QW-1]};
      rr_diff = rr - {1'b0, opd_ff};
      ge      = (rr >= {1'b0, opd_ff});
      rnd     = ({rem_ff, 1'b0} >= {1'b0, opd_ff});
      prod_sh = acc_ff >> FRAC_BITS;
      quot    = {1'b0, num_ff} + (QW+1)'(rnd);
   end

   // sequencer and iteration step
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      div_in    = div_ff;
      neg_in    = neg_ff;
      zero_in   = zero_ff;
      opd_in    = opd_ff;
      acc_in    = acc_ff;
      num_in    = num_ff;
      rem_in    = rem_ff;
      lo_in     = lo_ff;
      big_in    = big_ff;
      result_in = result_ff;
      ovf_in    = ovf_ff;
      case (state_ff)
         MDU_IDLE: begin
            if (start) begin
               div_in   = is_div;
               neg_in   = a[VAL_W-1] ^ b[VAL_W-1];
               zero_in  = (b == '0);
               state_in = MDU_RUN;
               if (is_div) begin
                  opd_in = mag_b;
                  num_in = QW'(mag_a) << FRAC_BITS;
                  rem_in = '0;
                  cnt_in = CNT_W'(QW - 1);
               end else begin
                  opd_in = mag_a;
                  acc_in = {HALF, mag_b};
                  cnt_in = CNT_W'(VAL_W - 1);
               end
            end
         end
         MDU_RUN: begin
            if (div_ff) begin
               rem_in = ge ? rr_diff[VAL_W-1:0] : rr[VAL_W-1:0];
               num_in = {num_ff[QW-2:0], ge};
            end else begin
               acc_in = {sum_hi, acc_ff[VAL_W-1:1]};
            end
            if (cnt_ff == '0) begin
               state_in = MDU_FIX;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         MDU_FIX: begin
            // round, then check the magnitude against the signed limit
            if (div_ff && zero_ff) begin
               lo_in  = '0;
               big_in = 1'b0;
            end else if (div_ff) begin
               lo_in  = quot[VAL_W-1:0];
               big_in = (|quot[QW:VAL_W]) || (quot[VAL_W-1:0] > lim);
            end else begin
               lo_in  = prod_sh[VAL_W-1:0];
               big_in = (|prod_sh[PW-1:VAL_W]) || (prod_sh[VAL_W-1:0] > lim);
            end
            state_in = MDU_SIGN;
         end
         MDU_SIGN: begin
            if (big_ff) begin
               result_in = neg_ff ? SMIN : SMAX;
            end else begin
               result_in = neg_ff ? (VAL_W'(0) - lo_ff) : lo_ff;
            end
            ovf_in   = big_ff;
            done_in  = 1'b1;
            state_in = MDU_IDLE;
         end
         default: begin
            state_in = MDU_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MDU_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      div_ff    <= div_in;
      neg_ff    <= neg_in;
      zero_ff   <= zero_in;
      opd_ff    <= opd_in;
      acc_ff    <= acc_in;
      num_ff    <= num_in;
      rem_ff    <= rem_in;
      lo_ff     <= lo_in;
      big_ff    <= big_in;
      result_ff <= result_in;
      ovf_ff    <= ovf_in;
   end

   assign done     = done_ff;
   assign result   = result_ff;
   assign overflow = ovf_ff;

   // checks
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == MDU_IDLE)
      else $error("mdu started while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("mdu done held longer than one cycle");
   a_done_from_sign: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(state_ff == MDU_SIGN))
      else $error("mdu done without final sign step");

endmodule

>>> rtl/ffc_dp.sv
// Calculator datapath: entry, stored value, pending operator, add/sub and result register
`timescale 1ns / 1ps

module ffc_dp #(
   parameter int MAX_DIGITS = 12,
   parameter int FRAC_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ffc_pkg::cmd_type              cmd,
   output ffc_pkg::status_type           status,
   input  logic [ffc_pkg::OPC_W-1:0]     opcode,
   input  logic [ffc_pkg::DIGIT_W-1:0]   digit_value,
   input  logic [ffc_pkg::KIND_W-1:0]    operator_kind,
   output logic [ffc_pkg::VAL_W-1:0]     display_value,
   output logic                          showing_entry,
   output logic                          overflow_flag
);
   import ffc_pkg::*;

   localparam int SAT_SHIFT = VAL_W - 1 - FRAC_BITS;

   // calculator state
   logic [ENTRY_W-1:0] entry_ff, entry_in;
   logic               present_ff, present_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [VAL_W-1:0]   stored_ff, stored_in;
   logic               valid_ff, valid_in;
   pend_type           pend_ff, pend_in;
   logic               ovf_ff, ovf_in;

   // current item and operand
   opcode_type         opc_ff, opc_in;
   logic [DIGIT_W-1:0] digit_ff, digit_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [VAL_W-1:0]   right_ff, right_in;

   // result register
   logic [VAL_W-1:0]   disp_ff, disp_in;
   logic               showing_ff, showing_in;
   logic               flag_ff, flag_in;

   logic [ENTRY_W-1:0] entry_next;
   logic [VAL_W:0]     fix_word;
   logic               entry_sat;
   logic [VAL_W-1:0]   entry_fix;
   logic [VAL_W-1:0]   sum, dif, sat_val;
   logic               add_ovf, sub_ovf;
   logic               mdu_done, mdu_ovf;
   logic [VAL_W-1:0]   mdu_res;

   // entry integer to fixed point, saturating; top bit is the saturation mark
   function automatic logic [VAL_W:0] to_fixed(input logic [ENTRY_W-1:0] e);
      logic [VAL_W-1:0] wide;
      logic             sat;
      wide = VAL_W'(e);
      sat  = |(wide >> SAT_SHIFT);
      return {sat, sat ? SMAX : (wide << FRAC_BITS)};
   endfunction

   ffc_mdu #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mdu (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.mdu_start),
      .is_div   (pend_ff == PEND_DIV),
      .a        (stored_ff),
      .b        (right_ff),
      .done     (mdu_done),
      .result   (mdu_res),
      .overflow (mdu_ovf)
   );

   // shared arithmetic
   always_comb begin
      entry_next = (entry_ff << 3) + (entry_ff << 1) + ENTRY_W'(digit_ff);
      fix_word   = to_fixed(entry_ff);
      entry_sat  = fix_word[VAL_W];
      entry_fix  = fix_word[VAL_W-1:0];
      sum        = stored_ff + right_ff;
      dif        = stored_ff - right_ff;
      add_ovf    = (stored_ff[VAL_W-1] ^ sum[VAL_W-1]) & (right_ff[VAL_W-1] ^ sum[VAL_W-1]);
      sub_ovf    = (stored_ff[VAL_W-1] ^ right_ff[VAL_W-1]) & (stored_ff[VAL_W-1] ^ dif[VAL_W-1]);
      sat_val    = stored_ff[VAL_W-1] ? SMIN : SMAX;
   end

   // next state from commands
   always_comb begin
      entry_in   = entry_ff;
      present_in = present_ff;
      count_in   = count_ff;
      stored_in  = stored_ff;
      valid_in   = valid_ff;
      pend_in    = pend_ff;
      ovf_in     = ovf_ff;
      opc_in     = opc_ff;
      digit_in   = digit_ff;
      kind_in    = kind_ff;
      right_in   = right_ff;
      disp_in    = disp_ff;
      showing_in = showing_ff;
      flag_in    = flag_ff;

      if (cmd.load_item) begin
         opc_in   = opcode_type'(opcode);
         digit_in = digit_value;
         kind_in  = operator_kind;
         ovf_in   = 1'b0;
      end

      // digit entry with leading-zero and length rules
      if (cmd.digit_step && (digit_ff <= DIGIT_MAX)) begin
         if (present_ff && (entry_ff == '0)) begin
            if (digit_ff != '0) begin
               entry_in = ENTRY_W'(digit_ff);
               count_in = COUNT_W'(1);
            end
         end else if (count_ff < COUNT_W'(MAX_DIGITS)) begin
            entry_in   = entry_next;
            count_in   = count_ff + COUNT_W'(1);
            present_in = 1'b1;
         end
      end

      if (cmd.clear_all) begin
         entry_in   = '0;
         present_in = 1'b0;
         count_in   = '0;
         stored_in  = '0;
         valid_in   = 1'b0;
         pend_in    = PEND_NONE;
      end

      if (cmd.convert) begin
         right_in = entry_fix;
         if (entry_sat) begin
            ovf_in = 1'b1;
         end
      end

      // new stored value, entry consumed
      if (cmd.write_stored) begin
         case (cmd.src)
            SRC_ADD: begin
               stored_in = add_ovf ? sat_val : sum;
               ovf_in    = ovf_ff | add_ovf;
            end
            SRC_SUB: begin
               stored_in = sub_ovf ? sat_val : dif;
               ovf_in    = ovf_ff | sub_ovf;
            end
            SRC_MDU: begin
               stored_in = mdu_res;
               ovf_in    = ovf_ff | mdu_ovf;
            end
            default: begin
               stored_in = right_ff;
            end
         endcase
         entry_in   = '0;
         present_in = 1'b0;
         count_in   = '0;
         valid_in   = 1'b1;
      end

      if (cmd.set_pend) begin
         pend_in = pend_type'(PEND_W'(kind_ff) + PEND_W'(1));
      end
      if (cmd.clr_pend) begin
         pend_in = PEND_NONE;
      end

      // shown value
      if (cmd.load_rsp) begin
         if (present_ff) begin
            disp_in = entry_fix;
         end else if (valid_ff) begin
            disp_in = stored_ff;
         end else begin
            disp_in = '0;
         end
         showing_in = present_ff;
         flag_in    = ovf_ff;
      end
   end

   // calculator state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff   <= '0;
         present_ff <= 1'b0;
         count_ff   <= '0;
         stored_ff  <= '0;
         valid_ff   <= 1'b0;
         pend_ff    <= PEND_NONE;
         ovf_ff     <= 1'b0;
      end else begin
         entry_ff   <= entry_in;
         present_ff <= present_in;
         count_ff   <= count_in;
         stored_ff  <= stored_in;
         valid_ff   <= valid_in;
         pend_ff    <= pend_in;
         ovf_ff     <= ovf_in;
      end
   end

   // item, operand and result payload
   always_ff @(posedge clock) begin
      opc_ff     <= opc_in;
      digit_ff   <= digit_in;
      kind_ff    <= kind_in;
      right_ff   <= right_in;
      disp_ff    <= disp_in;
      showing_ff <= showing_in;
      flag_ff    <= flag_in;
   end

   assign status.opcode        = opc_ff;
   assign status.entry_present = present_ff;
   assign status.stored_valid  = valid_ff;
   assign status.pend          = pend_ff;
   assign status.mdu_done      = mdu_done;

   assign display_value = disp_ff;
   assign showing_entry = showing_ff;
   assign overflow_flag = flag_ff;

endmodule

>>> rtl/ffc_ctrl.sv
// Calculator controller: event decode and sequencing of the datapath
`timescale 1ns / 1ps

module ffc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  ffc_pkg::status_type  status,
   output ffc_pkg::cmd_type     cmd
);
   import ffc_pkg::*;

   ctl_state_type state_ff, state_in;
   logic          eval_ff, eval_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      eval_in   = eval_ff;
      cmd       = '0;
      req_ready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               eval_in       = 1'b0;
               state_in      = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            case (status.opcode)
               OPC_DIGIT: begin
                  cmd.digit_step = 1'b1;
                  state_in       = ST_FINISH;
               end
               OPC_OPERATOR: begin
                  if (!status.entry_present && !status.stored_valid) begin
                     state_in = ST_FINISH;
                  end else if (status.entry_present) begin
                     eval_in  = status.stored_valid && (status.pend != PEND_NONE);
                     state_in = ST_CONVERT;
                  end else begin
                     cmd.set_pend = 1'b1;
                     state_in     = ST_FINISH;
                  end
               end
               OPC_EQUALS: begin
                  if (status.stored_valid && (status.pend != PEND_NONE) &&
                      status.entry_present) begin
                     eval_in  = 1'b1;
                     state_in = ST_CONVERT;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
               OPC_CLEAR: begin
                  cmd.clear_all = 1'b1;
                  state_in      = ST_FINISH;
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_CONVERT: begin
            cmd.convert = 1'b1;
            if (eval_ff && (status.pend inside {PEND_MUL, PEND_DIV})) begin
               state_in = ST_MDU_GO;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_MDU_GO: begin
            cmd.mdu_start = 1'b1;
            state_in      = ST_MDU_WAIT;
         end
         ST_MDU_WAIT: begin
            if (status.mdu_done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.write_stored = 1'b1;
            if (eval_ff) begin
               case (status.pend)
                  PEND_ADD: cmd.src = SRC_ADD;
                  PEND_SUB: cmd.src = SRC_SUB;
                  PEND_MUL: cmd.src = SRC_MDU;
                  PEND_DIV: cmd.src = SRC_MDU;
                  default:  cmd.src = SRC_RIGHT;
               endcase
            end else begin
               cmd.src = SRC_RIGHT;
            end
            if (status.opcode == OPC_OPERATOR) begin
               cmd.set_pend = 1'b1;
            end else begin
               cmd.clr_pend = 1'b1;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || cmd.load_rsp;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         eval_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         eval_ff      <= eval_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // checks
   a_pend_needs_stored: assert property (@(posedge clock) disable iff (reset)
      (status.pend != PEND_NONE) |-> status.stored_valid)
      else $error("operator pending without a stored value");
   a_eval_has_left: assert property (@(posedge clock) disable iff (reset)
      (cmd.write_stored && eval_ff) |-> status.stored_valid)
      else $error("evaluation without a left operand");
   a_mdu_start_op: assert property (@(posedge clock) disable iff (reset)
      cmd.mdu_start |-> (eval_ff && (status.pend == PEND_MUL || status.pend == PEND_DIV)))
      else $error("mdu started for a non multiply/divide operation");
   a_mdu_done_wait: assert property (@(posedge clock) disable iff (reset)
      status.mdu_done |-> (state_ff == ST_MDU_WAIT))
      else $error("mdu result arrived while not waiting");

endmodule

>>> rtl/four_function_calculator_control_top.sv
// Top level of the four-function calculator control block
//
//   channel    dir   handshake          payload
//   req_chan   in    valid/ready        opcode, digit_value, operator_kind
//   rsp_chan   out   valid/ready        display_value, showing_entry, overflow_flag
//
// One key event at a time; one display item per event. Multiply and divide
// run through the one-bit-per-cycle loop of the multiply/divide unit.
// The result sits in an output register; the next event is taken while it waits,
// and a stalled output only holds the block in its final step.
// Synchronous reset clears the entry, stored value, pending operator and handshakes.
`timescale 1ns / 1ps

module four_function_calculator_control_top #(
   parameter int MAX_DIGITS = 12,
   parameter int FRAC_BITS  = 16
) (
   input  logic      clock,
   input  logic      reset,
   ffc_req_if.sink   req_chan,
   ffc_rsp_if.source rsp_chan
);
   import ffc_pkg::*;

   cmd_type          cmd;
   status_type       status;
   logic [VAL_W-1:0] display_value;

   ffc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ffc_dp #(
      .MAX_DIGITS (MAX_DIGITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .opcode        (req_chan.opcode),
      .digit_value   (req_chan.digit_value),
      .operator_kind (req_chan.operator_kind),
      .display_value (display_value),
      .showing_entry (rsp_chan.showing_entry),
      .overflow_flag (rsp_chan.overflow_flag)
   );

   assign rsp_chan.display_value = display_value;

endmodule
